[design/idp_pkg.sv]
// Package with the codes, register offsets and shared types of the int8 dot-product device.
`timescale 1ns / 1ps
package idp_pkg;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [11:0] REG_ID         = 12'h000;
  localparam logic [11:0] REG_REVISION   = 12'h004;
  localparam logic [11:0] REG_CAPS       = 12'h008;
  localparam logic [11:0] REG_CTRL       = 12'h00C;
  localparam logic [11:0] REG_STATUS     = 12'h010;
  localparam logic [11:0] REG_IRQ_STATUS = 12'h014;
  localparam logic [11:0] REG_IRQ_ENABLE = 12'h018;
  localparam logic [11:0] REG_ERROR      = 12'h01C;
  localparam logic [11:0] REG_JOB_ID     = 12'h020;
  localparam logic [11:0] REG_LENGTH     = 12'h024;
  localparam logic [11:0] REG_RESULT     = 12'h140;
  localparam logic [11:0] REG_FAULT      = 12'h180;
  localparam logic [7:0]  OPA_PAGE       = 8'h10;
  localparam logic [7:0]  OPB_PAGE       = 8'h12;

  localparam logic [31:0] DEV_ID = 32'h564E_5055;
  localparam logic [31:0] CAPS_A = 32'h0000_003F;
  localparam logic [31:0] CAPS_B = 32'h0000_003D;
  localparam logic [31:0] LEN_SHORT = 32'd8;
  localparam logic [31:0] LEN_LONG  = 32'd16;
  localparam logic [15:0] BUSY_TICKS_RESET = 16'd100;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BUSY  = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;
  localparam logic [1:0] ST_ERROR = 2'd3;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_LENGTH = 2'd1;
  localparam logic [1:0] ERR_BUSY   = 2'd2;
  localparam logic [1:0] ERR_FORCED = 2'd3;

  localparam logic [1:0] IRQ_DONE = 2'b01;
  localparam logic [1:0] IRQ_ERR  = 2'b10;

  localparam int RESULT_W = 20;

  typedef struct packed {
    logic start;
    logic long_vector;
  } idp_mac_ctrl_t;

  typedef struct packed {
    logic                done;
    logic [RESULT_W-1:0] sum;
  } idp_mac_stat_t;

endpackage

[design/idp_if.sv]
// Channel interfaces of the int8 dot-product device: bus request, response and configuration.
`timescale 1ns / 1ps
interface idp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] offset;
  logic [31:0] write_data;
  logic        word_access;
  modport source (output valid, kind, offset, write_data, word_access, input ready);
  modport sink (input valid, kind, offset, write_data, word_access, output ready);
endinterface

interface idp_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_line;
  modport source (output valid, read_data, irq_line, input ready);
  modport sink (input valid, read_data, irq_line, output ready);
endinterface

interface idp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] busy_ticks;
  modport source (output valid, busy_ticks, input ready);
  modport sink (input valid, busy_ticks, output ready);
endinterface

[design/idp_mac.sv]
// Shared signed 8x8 multiply-accumulate unit that walks the operand lanes one per cycle, pausing to load each word.
`timescale 1ns / 1ps
module idp_mac (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  idp_pkg::idp_mac_ctrl_t ctrl_i,
  input  logic [31:0]            a_word_i,
  input  logic [31:0]            b_word_i,
  output logic [1:0]             addr_o,
  output idp_pkg::idp_mac_stat_t stat_o
);

  localparam logic [1:0] MS_IDLE = 2'd0;
  localparam logic [1:0] MS_LOAD = 2'd1;
  localparam logic [1:0] MS_RUN  = 2'd2;

  logic [1:0]                       state_q, state_d;
  logic [3:0]                       step_q, step_d;
  logic                             long_q, long_d;
  logic                             done_q, done_d;
  logic signed [idp_pkg::RESULT_W-1:0] acc_q, acc_d;
  logic signed [7:0]                a_lane, b_lane;
  logic signed [15:0]               prod;
  logic [1:0]                       last_word;

  assign a_lane    = a_word_i[8*step_q[1:0] +: 8];
  assign b_lane    = b_word_i[8*step_q[1:0] +: 8];
  assign prod      = a_lane * b_lane;
  assign last_word = long_q ? 2'd3 : 2'd1;
  assign addr_o    = step_q[3:2];
  assign stat_o.done = done_q;
  assign stat_o.sum  = acc_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    long_d  = long_q;
    acc_d   = acc_q;
    done_d  = 1'b0;
    unique case (state_q)
      MS_IDLE: begin
        if (ctrl_i.start) begin
          state_d = MS_LOAD;
          step_d  = 4'd0;
          long_d  = ctrl_i.long_vector;
          acc_d   = '0;
        end
      end
      MS_LOAD: begin
        state_d = MS_RUN;
      end
      MS_RUN: begin
        acc_d  = acc_q + {{(idp_pkg::RESULT_W-16){prod[15]}}, prod};
        step_d = step_q + 4'd1;
        if (step_q[1:0] == 2'd3) begin
          if (step_q[3:2] == last_word) begin
            state_d = MS_IDLE;
            done_d  = 1'b1;
          end else begin
            state_d = MS_LOAD;
          end
        end
      end
      default: begin
        state_d = MS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MS_IDLE;
      step_q  <= 4'd0;
      long_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      long_q  <= long_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> state_q == MS_IDLE)
    else $error("Multiply-accumulate start while a sum is in progress.");

  a_short_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != MS_IDLE && !long_q) |-> !addr_o[1])
    else $error("Short vector reads past the second operand word.");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("Sum completion lasted more than one cycle.");
`endif

endmodule

[design/int8_dot_product_device.sv]
// Top level of the register-mapped signed int8 dot-product device.
//
//   channel  direction  handshake          word
//   req_i    in         valid/ready        kind, offset, write_data, word_access
//   rsp_o    out        valid/ready        read_data, irq_line
//   cfg_i    in         valid/ready        busy_ticks (always ready)
//
// A read, a write or a non-completing tick passes through the fetch and execute states, its
// response word registered behind the registered read port of the operand memories.
// A completing tick then runs 8 lanes or 16: one lane per cycle through the shared
// multiply-accumulate unit, with a memory read per word and a final step to take the sum.
// The request channel is ready only in the idle state with the response register free
// or being emptied. Reset is asynchronous and clears all control state at once.
`timescale 1ns / 1ps
module int8_dot_product_device #(
  parameter int REVISION = 2
) (
  input logic       clk_i,
  input logic       rst_ni,
  idp_req_if.sink   req_i,
  idp_rsp_if.source rsp_o,
  idp_cfg_if.sink   cfg_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_MAC   = 2'd3;

  logic [1:0]  state_q, state_d;
  logic        in_ready;
  logic [1:0]  kind_q;
  logic [11:0] offset_q;
  logic [31:0] wdata_q;
  logic        word_q;

  logic [15:0] busy_ticks_q;
  logic [1:0]  status_q, status_d;
  logic [1:0]  err_q, err_d;
  logic [idp_pkg::RESULT_W-1:0] result_q, result_d;
  logic [1:0]  pend_q, pend_d;
  logic [1:0]  mask_q, mask_d;
  logic [3:0]  fault_q, fault_d;
  logic [31:0] job_q, job_d;
  logic        long_q, long_d;
  logic [15:0] ticks_q, ticks_d;

  logic [31:0] a_mem_q [4];
  logic [31:0] b_mem_q [4];
  logic [3:0]  a_vld_q, b_vld_q;
  logic [31:0] a_rd_q, b_rd_q;
  logic [1:0]  mem_addr;
  logic        a_we, b_we, a_hit, b_hit;

  logic        out_valid_q;
  logic [31:0] out_rd_q, rd_val;
  logic        out_irq_q;
  logic        out_load;
  logic        mac_start;
  logic [1:0]  mac_addr;
  idp_pkg::idp_mac_ctrl_t mac_ctrl;
  idp_pkg::idp_mac_stat_t mac_stat;

  assign in_ready     = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign req_i.ready  = in_ready;
  assign cfg_i.ready  = 1'b1;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_rd_q;
  assign rsp_o.irq_line  = out_irq_q;

  assign a_hit = (offset_q[11:4] == idp_pkg::OPA_PAGE) && (offset_q[1:0] == 2'd0);
  assign b_hit = (offset_q[11:4] == idp_pkg::OPB_PAGE) && (offset_q[1:0] == 2'd0);
  assign mem_addr = (state_q == S_MAC) ? mac_addr : offset_q[3:2];

  assign mac_ctrl.start       = mac_start;
  assign mac_ctrl.long_vector = long_q;

  idp_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .a_word_i (a_rd_q),
    .b_word_i (b_rd_q),
    .addr_o   (mac_addr),
    .stat_o   (mac_stat)
  );

  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    err_d     = err_q;
    result_d  = result_q;
    pend_d    = pend_q;
    mask_d    = mask_q;
    fault_d   = fault_q;
    job_d     = job_q;
    long_d    = long_q;
    ticks_d   = ticks_q;
    a_we      = 1'b0;
    b_we      = 1'b0;
    rd_val    = '0;
    mac_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid && in_ready) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (kind_q == idp_pkg::KIND_READ && word_q) begin
          if (a_hit) begin
            rd_val = a_rd_q;
          end else if (b_hit) begin
            rd_val = b_rd_q;
          end else begin
            unique case (offset_q)
              idp_pkg::REG_ID:         rd_val = idp_pkg::DEV_ID;
              idp_pkg::REG_REVISION:   rd_val = 32'(REVISION);
              idp_pkg::REG_CAPS:       rd_val = (REVISION == 2) ? idp_pkg::CAPS_B
                                                                : idp_pkg::CAPS_A;
              idp_pkg::REG_STATUS:     rd_val = {30'd0, status_q};
              idp_pkg::REG_IRQ_STATUS: rd_val = {30'd0, pend_q};
              idp_pkg::REG_IRQ_ENABLE: rd_val = {30'd0, mask_q};
              idp_pkg::REG_ERROR:      rd_val = {30'd0, err_q};
              idp_pkg::REG_JOB_ID:     rd_val = job_q;
              idp_pkg::REG_LENGTH:     rd_val = long_q ? idp_pkg::LEN_LONG
                                                       : idp_pkg::LEN_SHORT;
              idp_pkg::REG_RESULT: begin
                rd_val = {{(32-idp_pkg::RESULT_W){result_q[idp_pkg::RESULT_W-1]}},
                          result_q};
                if (status_q == idp_pkg::ST_DONE) begin
                  status_d = idp_pkg::ST_IDLE;
                end
              end
              idp_pkg::REG_FAULT:      rd_val = {28'd0, fault_q};
              default:                 rd_val = '0;
            endcase
          end
        end else if (kind_q == idp_pkg::KIND_WRITE && word_q) begin
          if (a_hit) begin
            a_we = 1'b1;
          end else if (b_hit) begin
            b_we = 1'b1;
          end else begin
            unique case (offset_q)
              idp_pkg::REG_CTRL: begin
                if (wdata_q[1]) begin
                  ticks_d  = '0;
                  status_d = idp_pkg::ST_IDLE;
                  pend_d   = '0;
                  err_d    = idp_pkg::ERR_NONE;
                  fault_d  = '0;
                end else if (wdata_q[0]) begin
                  if (status_q != idp_pkg::ST_IDLE) begin
                    pend_d = pend_q | idp_pkg::IRQ_ERR;
                    if (status_q == idp_pkg::ST_BUSY || status_q == idp_pkg::ST_DONE) begin
                      err_d = idp_pkg::ERR_BUSY;
                    end
                  end else begin
                    status_d = idp_pkg::ST_BUSY;
                    pend_d   = '0;
                    err_d    = idp_pkg::ERR_NONE;
                    ticks_d  = (busy_ticks_q == 16'd0) ? 16'd1 : busy_ticks_q;
                  end
                end
              end
              idp_pkg::REG_IRQ_STATUS: pend_d = pend_q & ~wdata_q[1:0];
              idp_pkg::REG_IRQ_ENABLE: mask_d = wdata_q[1:0];
              idp_pkg::REG_JOB_ID:     job_d  = wdata_q;
              idp_pkg::REG_LENGTH: begin
                if (wdata_q == idp_pkg::LEN_SHORT) begin
                  long_d = 1'b0;
                end else if (wdata_q == idp_pkg::LEN_LONG && REVISION == 2) begin
                  long_d = 1'b1;
                end else begin
                  err_d    = idp_pkg::ERR_LENGTH;
                  status_d = idp_pkg::ST_ERROR;
                  pend_d   = idp_pkg::IRQ_ERR;
                end
              end
              idp_pkg::REG_FAULT:      fault_d = wdata_q[3:0] & (~wdata_q[3:0] + 4'd1);
              default: begin
              end
            endcase
          end
        end else if (kind_q == idp_pkg::KIND_TICK && ticks_q != 16'd0) begin
          ticks_d = ticks_q - 16'd1;
          if (ticks_q == 16'd1) begin
            mac_start = 1'b1;
          end
        end
        if (mac_start) begin
          state_d = S_MAC;
        end else begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_MAC: begin
        if (mac_stat.done) begin
          result_d = mac_stat.sum;
          status_d = idp_pkg::ST_DONE;
          pend_d   = idp_pkg::IRQ_DONE;
          if (fault_q[0]) begin
            pend_d = '0;
          end else if (fault_q[1]) begin
            status_d = idp_pkg::ST_BUSY;
            pend_d   = '0;
          end else if (fault_q[2]) begin
            result_d = mac_stat.sum ^ {{(idp_pkg::RESULT_W-1){1'b0}}, 1'b1};
          end else if (fault_q[3]) begin
            status_d = idp_pkg::ST_ERROR;
            err_d    = idp_pkg::ERR_FORCED;
            pend_d   = idp_pkg::IRQ_ERR;
          end
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      busy_ticks_q <= idp_pkg::BUSY_TICKS_RESET;
      status_q     <= idp_pkg::ST_IDLE;
      err_q        <= idp_pkg::ERR_NONE;
      result_q     <= '0;
      pend_q       <= '0;
      mask_q       <= '0;
      fault_q      <= '0;
      job_q        <= '0;
      long_q       <= (REVISION == 2);
      ticks_q      <= '0;
      a_vld_q      <= '0;
      b_vld_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      err_q    <= err_d;
      result_q <= result_d;
      pend_q   <= pend_d;
      mask_q   <= mask_d;
      fault_q  <= fault_d;
      job_q    <= job_d;
      long_q   <= long_d;
      ticks_q  <= ticks_d;
      if (cfg_i.valid) begin
        busy_ticks_q <= cfg_i.busy_ticks;
      end
      if (a_we) begin
        a_vld_q[offset_q[3:2]] <= 1'b1;
      end
      if (b_we) begin
        b_vld_q[offset_q[3:2]] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && in_ready) begin
      kind_q   <= req_i.kind;
      offset_q <= req_i.offset;
      wdata_q  <= req_i.write_data;
      word_q   <= req_i.word_access;
    end
    if (out_load) begin
      out_rd_q  <= rd_val;
      out_irq_q <= |(pend_d & mask_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem_q[offset_q[3:2]] <= wdata_q;
    end
    if (b_we) begin
      b_mem_q[offset_q[3:2]] <= wdata_q;
    end
    a_rd_q <= a_vld_q[mem_addr] ? a_mem_q[mem_addr] : '0;
    b_rd_q <= b_vld_q[mem_addr] ? b_mem_q[mem_addr] : '0;
  end

`ifndef ASSERT_OFF
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req_i.ready)
    else $error("Request channel is ready while a word is in progress.");

  a_done_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_stat.done |-> state_q == S_MAC)
    else $error("Sum finished outside the completion state.");

  a_start_to_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_start |=> state_q == S_MAC)
    else $error("Job completion did not enter the completion state.");
`endif

endmodule
